@@ design/dspf_pkg.sv @@
// ---------------------------------------------------------------------------
// dspf_pkg
// Shared constants, types and helpers for the dual speed plausibility fusion
// block: window geometry, register indexes, reset values and the stage word.
// ---------------------------------------------------------------------------
package dspf_pkg;

  localparam int WINDOW_DEPTH = 3;
  localparam int DATA_W       = 16;
  localparam int SUM_W        = DATA_W + $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int DIV_K        = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W      = DIV_K + 1;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_GATE_LIMIT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_WARN_LIMIT = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] RAW_GATE_LIMIT_RST     = DATA_W'(640);
  localparam logic [DATA_W-1:0] AVERAGE_WARN_LIMIT_RST = DATA_W'(320);

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] raw_difference;
    logic [SUM_W-1:0]  wheel_sum;
    logic [SUM_W-1:0]  gps_sum;
    logic [CNT_W-1:0]  count;
  } sums_t;

  function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // ceil(2^DIV_K / n) by restoring long division, evaluated at elaboration
  function automatic logic [RECIP_W-1:0] recip(input int n);
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    num = 64'(1) << DIV_K;
    rem = '0;
    quo = '0;
    if (n == 0) begin
      return '0;
    end
    num = num + 64'(n) - 64'(1);
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= 64'(n)) begin
        rem = rem - 64'(n);
        quo[i] = 1'b1;
      end
    end
    return quo[RECIP_W-1:0];
  endfunction

endpackage

@@ design/dspf_window.sv @@
// ---------------------------------------------------------------------------
// dspf_window
// Input register, raw plausibility gate and the two circular speed windows.
// Registers the gate result, the raw difference, both window sums and the fill count per item.
// ---------------------------------------------------------------------------
module dspf_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dspf_pkg::DATA_W-1:0]   wheel_vel,
  input  logic [dspf_pkg::DATA_W-1:0]   gnss_vel,
  input  logic [dspf_pkg::DATA_W-1:0]   raw_gate_limit,
  output logic                          sums_valid,
  output dspf_pkg::sums_t               sums,
  input  logic                          sums_ready
);
  import dspf_pkg::*;

  logic              in_full;
  logic [DATA_W-1:0] wheel_q;
  logic [DATA_W-1:0] gps_q;
  logic [DATA_W-1:0] wheel_win [WINDOW_DEPTH];
  logic [DATA_W-1:0] gps_win [WINDOW_DEPTH];
  logic [DATA_W-1:0] wheel_win_next [WINDOW_DEPTH];
  logic [DATA_W-1:0] gps_win_next [WINDOW_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [DATA_W-1:0] pair_gap;
  logic              pass;
  logic              advance;
  logic              take;
  logic [SUM_W-1:0]  wheel_acc;
  logic [SUM_W-1:0]  gps_acc;

  assign advance  = !sums_valid || sums_ready;
  assign take     = in_full && advance;
  assign in_ready = !in_full || advance;

  assign pair_gap = abs_diff(wheel_q, gps_q);
  assign pass     = (pair_gap <= raw_gate_limit);

  always_comb begin
    wheel_acc = '0;
    gps_acc   = '0;
    slot_next = slot;
    fill_next = fill;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      wheel_win_next[i] = wheel_win[i];
      gps_win_next[i]   = gps_win[i];
    end
    if (pass) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (slot == SLOT_W'(i)) begin
          wheel_win_next[i] = wheel_q;
          gps_win_next[i]   = gps_q;
        end
      end
      slot_next = (slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
      if (fill != CNT_W'(WINDOW_DEPTH)) begin
        fill_next = fill + CNT_W'(1);
      end
    end
    // entries not yet filled still hold zero
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      wheel_acc = wheel_acc + SUM_W'(wheel_win_next[i]);
      gps_acc   = gps_acc + SUM_W'(gps_win_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      wheel_q <= wheel_vel;
      gps_q   <= gnss_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        wheel_win[i] <= '0;
        gps_win[i]   <= '0;
      end
      slot <= '0;
      fill <= '0;
    end else if (take) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        wheel_win[i] <= wheel_win_next[i];
        gps_win[i]   <= gps_win_next[i];
      end
      slot <= slot_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums_valid <= 1'b0;
    end else if (advance) begin
      sums_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sums.accepted       <= pass;
      sums.raw_difference <= pair_gap;
      sums.wheel_sum      <= wheel_acc;
      sums.gps_sum        <= gps_acc;
      sums.count          <= fill_next;
    end
  end

endmodule

@@ design/dspf_average.sv @@
// ---------------------------------------------------------------------------
// dspf_average
// Window averages by constant reciprocal multiply, average difference,
// mismatch warning and fused speed, held in the result register.
// ---------------------------------------------------------------------------
module dspf_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sums_valid,
  input  dspf_pkg::sums_t               sums,
  output logic                          sums_ready,
  input  logic [dspf_pkg::DATA_W-1:0]   average_warn_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [dspf_pkg::DATA_W-1:0]   raw_difference,
  output logic [dspf_pkg::DATA_W-1:0]   wheel_average,
  output logic [dspf_pkg::DATA_W-1:0]   gps_average,
  output logic [dspf_pkg::DATA_W-1:0]   average_difference,
  output logic                          mismatch_warning,
  output logic [dspf_pkg::DATA_W-1:0]   fused_speed
);
  import dspf_pkg::*;

  localparam int TAB_N = 2 ** CNT_W;

  logic [RECIP_W-1:0] recip_tab [TAB_N];
  logic [RECIP_W-1:0] factor;
  logic [PROD_W-1:0]  wheel_prod;
  logic [PROD_W-1:0]  gps_prod;
  logic [DATA_W-1:0]  wheel_avg;
  logic [DATA_W-1:0]  gps_avg;
  logic [DATA_W-1:0]  mean_gap;
  logic               warn;
  logic [DATA_W:0]    avg_total;

  // empty window and unused counts map to zero
  for (genvar n = 0; n < TAB_N; n++) begin : g_recip
    assign recip_tab[n] = (n <= WINDOW_DEPTH) ? recip(n) : '0;
  end

  assign factor     = recip_tab[sums.count];
  assign wheel_prod = PROD_W'(sums.wheel_sum) * PROD_W'(factor);
  assign gps_prod   = PROD_W'(sums.gps_sum) * PROD_W'(factor);
  assign wheel_avg  = wheel_prod[DIV_K +: DATA_W];
  assign gps_avg    = gps_prod[DIV_K +: DATA_W];
  assign mean_gap   = abs_diff(wheel_avg, gps_avg);
  assign warn       = (mean_gap > average_warn_limit);
  assign avg_total  = {1'b0, wheel_avg} + {1'b0, gps_avg};

  assign sums_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sums_ready) begin
      out_valid <= sums_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sums_valid && sums_ready) begin
      accepted           <= sums.accepted;
      raw_difference     <= sums.raw_difference;
      wheel_average      <= wheel_avg;
      gps_average        <= gps_avg;
      average_difference <= mean_gap;
      mismatch_warning   <= warn;
      fused_speed        <= warn ? '0 : avg_total[DATA_W:1];
    end
  end

endmodule

@@ design/dual_speed_plausibility_fusion_unit.sv @@
// ---------------------------------------------------------------------------
// dual_speed_plausibility_fusion_unit
// Wheel and GPS speed plausibility gate with 3-deep moving averages and a
// fused speed output.
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready with wheel_vel and gnss_vel, one word
//   per pair of speeds in 1/64 km/h. output channel: out_valid/out_ready, one
//   result word per input word, in order.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is the raw gate limit, index 1 the average warning limit, other indexes
//   are ignored. cfg_ready is always high; write only while the block is
//   empty.
//   path: a word taken at the input goes through the input register, then
//   the gate and window sum register, then the result register.
//   throughput: one word per cycle while out_ready is high, bounded by the
//   window update that each word makes in the gate stage.
//   reset: windows, write slot and fill count clear, limits return to 640
//   and 320, all stages empty.
//   stall: when out_ready is low the stages fill up and in_ready drops after
//   up to three words; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module dual_speed_plausibility_fusion_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dspf_pkg::DATA_W-1:0]       wheel_vel,
  input  logic [dspf_pkg::DATA_W-1:0]       gnss_vel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic [dspf_pkg::DATA_W-1:0]       raw_difference,
  output logic [dspf_pkg::DATA_W-1:0]       wheel_average,
  output logic [dspf_pkg::DATA_W-1:0]       gps_average,
  output logic [dspf_pkg::DATA_W-1:0]       average_difference,
  output logic                              mismatch_warning,
  output logic [dspf_pkg::DATA_W-1:0]       fused_speed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dspf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dspf_pkg::DATA_W-1:0]       cfg_data
);
  import dspf_pkg::*;

  logic [DATA_W-1:0] raw_gate_limit;
  logic [DATA_W-1:0] average_warn_limit;
  logic              sums_valid;
  logic              sums_ready;
  sums_t             sums;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_gate_limit     <= RAW_GATE_LIMIT_RST;
      average_warn_limit <= AVERAGE_WARN_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RAW_GATE_LIMIT:     raw_gate_limit     <= cfg_data;
        REG_AVERAGE_WARN_LIMIT: average_warn_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  dspf_window u_window (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .wheel_vel      (wheel_vel),
    .gnss_vel       (gnss_vel),
    .raw_gate_limit (raw_gate_limit),
    .sums_valid     (sums_valid),
    .sums           (sums),
    .sums_ready     (sums_ready)
  );

  dspf_average u_average (
    .clk                (clk),
    .rst                (rst),
    .sums_valid         (sums_valid),
    .sums               (sums),
    .sums_ready         (sums_ready),
    .average_warn_limit (average_warn_limit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .accepted           (accepted),
    .raw_difference     (raw_difference),
    .wheel_average      (wheel_average),
    .gps_average        (gps_average),
    .average_difference (average_difference),
    .mismatch_warning   (mismatch_warning),
    .fused_speed        (fused_speed)
  );

  a_gate_matches_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (raw_difference <= raw_gate_limit)))
    else $error("gate decision disagrees with raw difference");

  a_warn_matches_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mismatch_warning == (average_difference > average_warn_limit)))
    else $error("mismatch warning disagrees with average difference");

  a_warn_blanks_fused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mismatch_warning) |-> (fused_speed == '0))
    else $error("fused speed not blanked under mismatch warning");

  a_stage_backpressure: assert property (@(posedge clk) disable iff (rst)
    (sums_valid && out_valid && !out_ready) |-> !sums_ready)
    else $error("gate stage advanced into a stalled result register");

endmodule

@@ verif/dual_speed_plausibility_fusion_unit_tb.sv @@
// ---------------------------------------------------------------------------
// dual_speed_plausibility_fusion_unit_tb
// Self-checking bench for the wheel/GPS speed plausibility fusion unit. A
// scoreboard keeps its own copy of both speed windows and of the limits,
// works out every result word as input words are taken, and compares result
// words field by field in order. Stimulus runs a directed pass over gate and
// warning edges, then random phases at several limit settings with random
// stalls on both channels.
// ---------------------------------------------------------------------------

typedef struct packed {
  logic                        accepted;
  logic [dspf_pkg::DATA_W-1:0] raw_difference;
  logic [dspf_pkg::DATA_W-1:0] wheel_average;
  logic [dspf_pkg::DATA_W-1:0] gps_average;
  logic [dspf_pkg::DATA_W-1:0] average_difference;
  logic                        mismatch_warning;
  logic [dspf_pkg::DATA_W-1:0] fused_speed;
} fusion_word_t;

class fusion_scoreboard;
  logic [dspf_pkg::DATA_W-1:0] gate_limit;
  logic [dspf_pkg::DATA_W-1:0] warn_limit;
  logic [dspf_pkg::DATA_W-1:0] wheel_win [dspf_pkg::WINDOW_DEPTH];
  logic [dspf_pkg::DATA_W-1:0] gps_win   [dspf_pkg::WINDOW_DEPTH];
  int unsigned                 slot;
  int unsigned                 fill;
  fusion_word_t                pending_words [$];
  int unsigned                 fails;

  function new();
    gate_limit = dspf_pkg::RAW_GATE_LIMIT_RST;
    warn_limit = dspf_pkg::AVERAGE_WARN_LIMIT_RST;
    foreach (wheel_win[i]) begin
      wheel_win[i] = '0;
      gps_win[i]   = '0;
    end
    slot  = 0;
    fill  = 0;
    fails = 0;
  endfunction

  function void write_reg(logic [dspf_pkg::CFG_IDX_W-1:0] idx,
                          logic [dspf_pkg::DATA_W-1:0] data);
    if (idx == dspf_pkg::REG_RAW_GATE_LIMIT) begin
      gate_limit = data;
    end else if (idx == dspf_pkg::REG_AVERAGE_WARN_LIMIT) begin
      warn_limit = data;
    end
  endfunction

  function logic [dspf_pkg::DATA_W-1:0] span(logic [dspf_pkg::DATA_W-1:0] a,
                                             logic [dspf_pkg::DATA_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function logic [dspf_pkg::DATA_W-1:0] window_mean(
      logic [dspf_pkg::DATA_W-1:0] win [dspf_pkg::WINDOW_DEPTH]);
    int unsigned total;
    total = 0;
    if (fill == 0) begin
      return '0;
    end
    for (int i = 0; i < fill; i++) begin
      total += win[i];
    end
    return dspf_pkg::DATA_W'(total / fill);
  endfunction

  function void note_pair(logic [dspf_pkg::DATA_W-1:0] wheel,
                          logic [dspf_pkg::DATA_W-1:0] gps);
    fusion_word_t              want;
    logic [dspf_pkg::DATA_W:0] both;
    want.raw_difference = span(wheel, gps);
    want.accepted       = want.raw_difference <= gate_limit;
    if (want.accepted) begin
      wheel_win[slot] = wheel;
      gps_win[slot]   = gps;
      slot = (slot + 1 == dspf_pkg::WINDOW_DEPTH) ? 0 : slot + 1;
      if (fill < dspf_pkg::WINDOW_DEPTH) begin
        fill++;
      end
    end
    want.wheel_average      = window_mean(wheel_win);
    want.gps_average        = window_mean(gps_win);
    want.average_difference = span(want.wheel_average, want.gps_average);
    want.mismatch_warning   = want.average_difference > warn_limit;
    both = {1'b0, want.wheel_average} + {1'b0, want.gps_average};
    want.fused_speed = want.mismatch_warning ? '0 : both[dspf_pkg::DATA_W:1];
    pending_words.push_back(want);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endfunction

  function void check_word(fusion_word_t got);
    fusion_word_t want;
    if (pending_words.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("%0t: result word with nothing outstanding: %p", $time, got);
      end
      return;
    end
    want = pending_words.pop_front();
    compare_field("accepted", want.accepted, got.accepted);
    compare_field("raw_difference", want.raw_difference, got.raw_difference);
    compare_field("wheel_average", want.wheel_average, got.wheel_average);
    compare_field("gps_average", want.gps_average, got.gps_average);
    compare_field("average_difference", want.average_difference,
                  got.average_difference);
    compare_field("mismatch_warning", want.mismatch_warning, got.mismatch_warning);
    compare_field("fused_speed", want.fused_speed, got.fused_speed);
  endfunction
endclass

module dual_speed_plausibility_fusion_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dspf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFE;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [dspf_pkg::DATA_W-1:0] SPEED_MAX = '1;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [dspf_pkg::DATA_W-1:0]       wheel_vel;
  logic [dspf_pkg::DATA_W-1:0]       gnss_vel;
  logic                              out_valid;
  logic                              out_ready;
  logic                              accepted;
  logic [dspf_pkg::DATA_W-1:0]       raw_difference;
  logic [dspf_pkg::DATA_W-1:0]       wheel_average;
  logic [dspf_pkg::DATA_W-1:0]       gps_average;
  logic [dspf_pkg::DATA_W-1:0]       average_difference;
  logic                              mismatch_warning;
  logic [dspf_pkg::DATA_W-1:0]       fused_speed;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [dspf_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [dspf_pkg::DATA_W-1:0]       cfg_data;

  fusion_scoreboard scb = new();
  bit               steady;
  int unsigned      stall_left;

  dual_speed_plausibility_fusion_unit dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .wheel_vel          (wheel_vel),
    .gnss_vel           (gnss_vel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .accepted           (accepted),
    .raw_difference     (raw_difference),
    .wheel_average      (wheel_average),
    .gps_average        (gps_average),
    .average_difference (average_difference),
    .mismatch_warning   (mismatch_warning),
    .fused_speed        (fused_speed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      scb.check_word({accepted, raw_difference, wheel_average, gps_average,
                      average_difference, mismatch_warning, fused_speed});
    end
  end

  // result side backpressure
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 25) begin
        out_ready  = 1'b0;
        stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                : $urandom_range(5, 40);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // starts and ends on a falling edge
  task automatic send_pair(input logic [dspf_pkg::DATA_W-1:0] wheel,
                           input logic [dspf_pkg::DATA_W-1:0] gps);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    wheel_vel = wheel;
    gnss_vel  = gps;
    do @(posedge clk); while (!in_ready);
    scb.note_pair(wheel, gps);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [dspf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dspf_pkg::DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    scb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (scb.pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limits(input logic [dspf_pkg::DATA_W-1:0] gate,
                            input logic [dspf_pkg::DATA_W-1:0] warn);
    write_reg(dspf_pkg::REG_RAW_GATE_LIMIT, gate);
    write_reg(dspf_pkg::REG_AVERAGE_WARN_LIMIT, warn);
  endtask

  // mostly plausible pairs around the gate, some unrelated noise
  function automatic void draw_pair(output logic [dspf_pkg::DATA_W-1:0] wheel,
                                    output logic [dspf_pkg::DATA_W-1:0] gps);
    int unsigned roll;
    int          base;
    int          other;
    int          delta;
    int          reach;
    roll = $urandom_range(0, 99);
    base = (roll < 4) ? 0 : (roll < 8) ? int'(SPEED_MAX) : int'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 75) begin
      reach = (scb.gate_limit > 65533) ? 65535 : int'(scb.gate_limit) + 2;
      roll  = $urandom_range(0, 99);
      if (roll < 10) begin
        delta = int'(scb.gate_limit) + int'($urandom_range(0, 1));
      end else if (roll < 70) begin
        delta = $urandom_range(0, reach / 2);
      end else begin
        delta = $urandom_range(0, reach);
      end
      if ($urandom_range(0, 1) && base + delta <= 65535) begin
        other = base + delta;
      end else if (base >= delta) begin
        other = base - delta;
      end else begin
        other = (base + delta > 65535) ? 65535 : base + delta;
      end
    end else begin
      other = $urandom_range(0, 65535);
    end
    if ($urandom_range(0, 1)) begin
      wheel = base[15:0];
      gps   = other[15:0];
    end else begin
      wheel = other[15:0];
      gps   = base[15:0];
    end
  endfunction

  task automatic run_phase(input int unsigned count);
    logic [dspf_pkg::DATA_W-1:0] wheel;
    logic [dspf_pkg::DATA_W-1:0] gps;
    for (int unsigned i = 0; i < count; i++) begin
      steady = (i < count / 5);
      if (i == count / 2) begin
        wait_idle();
      end
      draw_pair(wheel, gps);
      send_pair(wheel, gps);
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    wheel_vel = '0;
    gnss_vel  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset limits: empty windows, gate edge, slot wrap, warning edge
    send_pair(16'd0, SPEED_MAX);
    send_pair(16'd0, 16'd0);
    send_pair(SPEED_MAX, SPEED_MAX);
    send_pair(SPEED_MAX, 16'd64895);
    send_pair(16'd100, 16'd741);
    send_pair(16'd741, 16'd100);
    send_pair(16'd1000, 16'd1640);
    send_pair(16'd1000, 16'd1640);
    send_pair(16'd1640, 16'd1000);
    send_pair(16'd1000, 16'd1640);
    send_pair(16'd2000, 16'd2320);
    send_pair(16'd2000, 16'd2320);
    send_pair(16'd2000, 16'd2320);
    send_pair(16'd2000, 16'd2321);
    send_pair(16'd2000, 16'd2321);
    send_pair(16'd2000, 16'd2321);
    send_pair(16'd12345, 16'd12345);
    send_pair(16'd0, 16'd640);
    wait_idle();

    run_phase(300);
    set_limits(16'd0, 16'd0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    run_phase(250);
    set_limits(SPEED_MAX, SPEED_MAX);
    run_phase(250);
    set_limits(SPEED_MAX, 16'd0);
    run_phase(250);
    set_limits(16'd16, 16'd8);
    run_phase(250);
    set_limits(dspf_pkg::DATA_W'($urandom_range(0, 65535)),
               dspf_pkg::DATA_W'($urandom_range(0, 4095)));
    run_phase(300);
    set_limits(dspf_pkg::RAW_GATE_LIMIT_RST, dspf_pkg::AVERAGE_WARN_LIMIT_RST);
    run_phase(300);

    if (scb.fails == 0 && scb.pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
